FILE: rtl/swoa_pkg.sv
// ----------------------------------------------------------------------------
// swoa_pkg
// Shared types, constants and index helpers for the sonar window obstacle
// avoid block.
// ----------------------------------------------------------------------------
package swoa_pkg;

	// table geometry
	localparam int SENSORS      = 32;
	localparam int TBL_IDX_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1;

	// field widths
	localparam int SENSOR_IDX_W = 5;
	localparam int RANGE_W      = 16;
	localparam int SPEED_W      = 13;
	localparam int RATE_W       = 13;
	localparam int TURN_W       = 14;

	// common width for comparing a sensor index against the table size
	localparam int IDX_X_W = ((TBL_IDX_W > SENSOR_IDX_W) ? TBL_IDX_W : SENSOR_IDX_W) + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_AVOID_DISTANCE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_HALT_DISTANCE  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE      = CFG_IDX_W'(5);

	// register reset values
	localparam logic [SENSOR_IDX_W-1:0] RST_WINDOW_LEFT    = SENSOR_IDX_W'(0);
	localparam logic [SENSOR_IDX_W-1:0] RST_WINDOW_RIGHT   = SENSOR_IDX_W'(7);
	localparam logic [RANGE_W-1:0]      RST_AVOID_DISTANCE = RANGE_W'(1000);
	localparam logic [RANGE_W-1:0]      RST_HALT_DISTANCE  = RANGE_W'(300);
	localparam logic [SPEED_W-1:0]      RST_CRUISE_SPEED   = SPEED_W'(200);
	localparam logic [RATE_W-1:0]       RST_TURN_RATE      = RATE_W'(500);

	// configuration register file
	typedef struct packed {
		logic [SENSOR_IDX_W-1:0] window_left;
		logic [SENSOR_IDX_W-1:0] window_right;
		logic [RANGE_W-1:0]      avoid_distance;
		logic [RANGE_W-1:0]      halt_distance;
		logic signed [SPEED_W-1:0] cruise_speed;
		logic [RATE_W-1:0]       turn_rate;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic wr;        // store the incoming reading
		logic start;     // load the walk address with the window low end
		logic walk;      // read one table entry and advance
		logic load_res;  // capture the result word into the output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic at_hi;     // walk address sits on the window high end
		logic out_free;  // output register can take a new word this cycle
	} sts_t;

	// true when a sensor index has an entry in the table
	function automatic logic in_table(input logic [SENSOR_IDX_W-1:0] v);
		logic [IDX_X_W-1:0] vx;
		vx = IDX_X_W'(v);
		return vx < IDX_X_W'(SENSORS);
	endfunction

	// table address of a sensor index (meaningful when in_table holds)
	function automatic logic [TBL_IDX_W-1:0] tbl_addr(input logic [SENSOR_IDX_W-1:0] v);
		logic [IDX_X_W-1:0] vx;
		vx = IDX_X_W'(v);
		return vx[TBL_IDX_W-1:0];
	endfunction

	// window end clamped to the last table entry
	function automatic logic [TBL_IDX_W-1:0] sat_index(input logic [SENSOR_IDX_W-1:0] v);
		logic [IDX_X_W-1:0] vx;
		vx = IDX_X_W'(v);
		if (vx >= IDX_X_W'(SENSORS - 1)) begin
			return TBL_IDX_W'(SENSORS - 1);
		end
		return vx[TBL_IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/swoa_ctrl.sv
// ----------------------------------------------------------------------------
// swoa_ctrl
// Sequencer: stores readings, runs the window walk on a scan end word and
// hands the result word to the output register.
// ----------------------------------------------------------------------------
module swoa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               scan_end,
	output logic               in_stall,
	input  swoa_pkg::sts_t     sts,
	output swoa_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_MIN  = 4'b0100,
		ST_RES  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr = in_valid;
				if (in_valid && scan_end) begin
					cmd.start = 1'b1;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.at_hi) begin
					state_d = ST_MIN;
				end
			end
			ST_MIN: begin
				// last entry of the window settles into the minimum
				state_d = ST_RES;
			end
			ST_RES: begin
				if (sts.out_free) begin
					cmd.load_res = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/swoa_dp.sv
// ----------------------------------------------------------------------------
// swoa_dp
// Datapath: configuration registers, range table, window walk with running
// minimum, result math and output register.
// ----------------------------------------------------------------------------
module swoa_dp (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [swoa_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [swoa_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic [swoa_pkg::SENSOR_IDX_W-1:0]        sensor_index,
	input  logic [swoa_pkg::RANGE_W-1:0]             range_mm,
	input  swoa_pkg::cmd_t                           cmd,
	output swoa_pkg::sts_t                           sts,
	input  logic                                     out_stall,
	output logic                                     out_valid,
	output logic                                     active,
	output logic signed [swoa_pkg::SPEED_W-1:0]      speed_cmd,
	output logic signed [swoa_pkg::TURN_W-1:0]       turn_cmd
);

	swoa_pkg::cfg_t cfg_q;

	logic [swoa_pkg::RANGE_W-1:0]   mem [swoa_pkg::SENSORS];
	logic [swoa_pkg::SENSORS-1:0]   vld_q;
	logic                           wr_hit;
	logic [swoa_pkg::TBL_IDX_W-1:0] wr_addr;

	logic [swoa_pkg::TBL_IDX_W-1:0] left;
	logic [swoa_pkg::TBL_IDX_W-1:0] right;
	logic [swoa_pkg::TBL_IDX_W-1:0] lo;
	logic [swoa_pkg::TBL_IDX_W-1:0] hi;

	logic [swoa_pkg::TBL_IDX_W-1:0] addr_q;
	logic                           first_q;
	logic                           rd_en_s1;
	logic                           first_s1;
	logic                           rd_vld_s1;
	logic [swoa_pkg::RANGE_W-1:0]   rd_data_s1;
	logic [swoa_pkg::TBL_IDX_W-1:0] addr_s1;
	logic [swoa_pkg::RANGE_W-1:0]   rd_val;

	logic [swoa_pkg::RANGE_W-1:0]   min_q;
	logic [swoa_pkg::TBL_IDX_W-1:0] id_q;

	logic                               act_d;
	logic signed [swoa_pkg::SPEED_W-1:0] speed_d;
	logic signed [swoa_pkg::TURN_W-1:0]  turn_d;
	logic signed [swoa_pkg::TURN_W-1:0]  rate_x;
	logic [swoa_pkg::TBL_IDX_W-1:0]     dist_l;
	logic [swoa_pkg::TBL_IDX_W-1:0]     dist_r;

	logic                               out_valid_q;
	logic                               active_q;
	logic signed [swoa_pkg::SPEED_W-1:0] speed_q;
	logic signed [swoa_pkg::TURN_W-1:0]  turn_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_left    <= swoa_pkg::RST_WINDOW_LEFT;
			cfg_q.window_right   <= swoa_pkg::RST_WINDOW_RIGHT;
			cfg_q.avoid_distance <= swoa_pkg::RST_AVOID_DISTANCE;
			cfg_q.halt_distance  <= swoa_pkg::RST_HALT_DISTANCE;
			cfg_q.cruise_speed   <= swoa_pkg::RST_CRUISE_SPEED;
			cfg_q.turn_rate      <= swoa_pkg::RST_TURN_RATE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swoa_pkg::REG_WINDOW_LEFT:
					cfg_q.window_left <= cfg_data[swoa_pkg::SENSOR_IDX_W-1:0];
				swoa_pkg::REG_WINDOW_RIGHT:
					cfg_q.window_right <= cfg_data[swoa_pkg::SENSOR_IDX_W-1:0];
				swoa_pkg::REG_AVOID_DISTANCE:
					cfg_q.avoid_distance <= cfg_data[swoa_pkg::RANGE_W-1:0];
				swoa_pkg::REG_HALT_DISTANCE:
					cfg_q.halt_distance <= cfg_data[swoa_pkg::RANGE_W-1:0];
				swoa_pkg::REG_CRUISE_SPEED:
					cfg_q.cruise_speed <= $signed(cfg_data[swoa_pkg::SPEED_W-1:0]);
				swoa_pkg::REG_TURN_RATE:
					cfg_q.turn_rate <= cfg_data[swoa_pkg::RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// window ends, clamped and ordered
	always_comb begin
		left  = swoa_pkg::sat_index(cfg_q.window_left);
		right = swoa_pkg::sat_index(cfg_q.window_right);
		if (left <= right) begin
			lo = left;
			hi = right;
		end else begin
			lo = right;
			hi = left;
		end
	end

	// range table write, readings beyond the table are dropped
	assign wr_hit  = cmd.wr && swoa_pkg::in_table(sensor_index);
	assign wr_addr = swoa_pkg::tbl_addr(sensor_index);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_addr] <= range_mm;
		end
	end

	// registered table read for the walk
	always_ff @(posedge clk) begin
		if (cmd.walk) begin
			rd_data_s1 <= mem[addr_q];
		end
		addr_s1 <= addr_q;
	end

	// entry valid bits and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			addr_q    <= '0;
			first_q   <= 1'b0;
			rd_en_s1  <= 1'b0;
			first_s1  <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_hit) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_en_s1 <= cmd.walk;
			if (cmd.start) begin
				addr_q  <= lo;
				first_q <= 1'b1;
			end else if (cmd.walk) begin
				addr_q    <= addr_q + swoa_pkg::TBL_IDX_W'(1);
				first_q   <= 1'b0;
				first_s1  <= first_q;
				rd_vld_s1 <= vld_q[addr_q];
			end
		end
	end

	assign sts.at_hi = (addr_q == hi);

	// an entry never written reads as zero
	assign rd_val = rd_vld_s1 ? rd_data_s1 : '0;

	// running minimum, lowest index wins ties
	always_ff @(posedge clk) begin
		if (rd_en_s1 && (first_s1 || (rd_val < min_q))) begin
			min_q <= rd_val;
			id_q  <= addr_s1;
		end
	end

	// result word
	always_comb begin
		act_d  = (min_q < cfg_q.avoid_distance);
		dist_l = (id_q > left) ? (id_q - left) : (left - id_q);
		dist_r = (id_q > right) ? (id_q - right) : (right - id_q);
		rate_x = $signed({1'b0, cfg_q.turn_rate});
		speed_d = '0;
		turn_d  = '0;
		if (act_d) begin
			if (min_q >= cfg_q.halt_distance) begin
				speed_d = cfg_q.cruise_speed;
			end
			turn_d = (dist_l > dist_r) ? rate_x : -rate_x;
		end
	end

	// output register
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			active_q <= act_d;
			speed_q  <= speed_d;
			turn_q   <= turn_d;
		end
	end

	assign out_valid = out_valid_q;
	assign active    = active_q;
	assign speed_cmd = speed_q;
	assign turn_cmd  = turn_q;

`ifndef SYNTHESIS
	// walk stays inside the ordered window
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (addr_q >= lo && addr_q <= hi))
		else $error("walk address outside window");

	// no table write while a walk is running
	a_no_wr_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !cmd.walk)
		else $error("table write during walk");

	// running minimum never grows after the first entry
	a_min_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en_s1 && !first_s1) |=> (min_q <= $past(min_q)))
		else $error("window minimum increased");

	// a new output word only follows a result load
	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load_res))
		else $error("output valid without result load");
`endif

endmodule

FILE: rtl/sonar_window_obstacle_avoid_core.sv
// ----------------------------------------------------------------------------
// sonar_window_obstacle_avoid_core
// Sonar frontal window obstacle avoid reflex: stores range readings and, at
// the end of each scan, emits one motion command from the window minimum.
// ----------------------------------------------------------------------------
// Usage
// Input channel (in_valid / in_stall) carries one reading per word: sensor
// index, range and a scan end flag. Ordinary readings are stored in the range
// table, and the block takes a word every cycle while in_stall is low.
// A word with scan_end set is stored, then the table is walked over the
// inclusive window between window_left and window_right (ends clamped to the
// last sensor and ordered), one entry per cycle through the single table read
// port. in_stall stays high through the walk, the settle state and the result
// state, and the output word is loaded as the block returns to idle.
// Output channel (out_valid / out_stall) holds one result word in a register;
// while it is stalled, plain readings are still taken, and a scan end word
// waits with its result until the register frees up, stalling the input.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge; the user must write only while idle; the block does not enforce it.
// Reset clears the output register and marks every table entry unwritten so
// that it reads as zero range, and restores the register defaults.
// ----------------------------------------------------------------------------
module sonar_window_obstacle_avoid_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [swoa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [swoa_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [swoa_pkg::SENSOR_IDX_W-1:0]     sensor_index,
	input  logic [swoa_pkg::RANGE_W-1:0]          range_mm,
	input  logic                                  scan_end,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  active,
	output logic signed [swoa_pkg::SPEED_W-1:0]   speed_cmd,
	output logic signed [swoa_pkg::TURN_W-1:0]    turn_cmd
);

	swoa_pkg::cmd_t cmd;
	swoa_pkg::sts_t sts;

	// sequencer
	swoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.scan_end (scan_end),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, walk and result datapath
	swoa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sensor_index (sensor_index),
		.range_mm     (range_mm),
		.cmd          (cmd),
		.sts          (sts),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.active       (active),
		.speed_cmd    (speed_cmd),
		.turn_cmd     (turn_cmd)
	);

endmodule
